// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL; all checks sample on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== src/hbe_pkg.sv =====
package hbe_pkg;

   localparam int BYTE_BITS = 8;
   localparam int SYM_W     = 8;
   localparam int CODE_W    = 16;
   localparam int LEN_W     = 5;
   localparam int PEND_W    = BYTE_BITS - 1;
   localparam int PCNT_W    = 3;
   localparam int ACC_W     = PEND_W + CODE_W;
   localparam int ACNT_W    = 5;
   localparam int OCNT_W    = 4;
   localparam int NRES_W    = 2;

   localparam logic [OCNT_W-1:0] FULL_BYTE_COUNT = OCNT_W'(BYTE_BITS);

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef struct packed {
      logic      valid;
      logic      flush;
      entry_type entry;
   } pack_in_type;

   typedef struct packed {
      logic [NRES_W-1:0]    n;
      logic [BYTE_BITS-1:0] byte0;
      logic [OCNT_W-1:0]    count0;
      logic                 eos0;
      logic [BYTE_BITS-1:0] byte1;
   } pack_out_type;

endpackage

// ===== src/hbe_req_if.sv =====
interface hbe_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [hbe_pkg::SYM_W-1:0]   req_symbol;
   logic [hbe_pkg::CODE_W-1:0]  req_code_word;
   logic [hbe_pkg::LEN_W-1:0]   req_code_length;

   modport source (output valid, req_type, req_symbol, req_code_word, req_code_length,
                   input ready);
   modport sink   (input valid, req_type, req_symbol, req_code_word, req_code_length,
                   output ready);
endinterface

// ===== src/hbe_rsp_if.sv =====
interface hbe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hbe_pkg::BYTE_BITS-1:0]  rsp_out_byte;
   logic [hbe_pkg::OCNT_W-1:0]     rsp_out_bit_count;
   logic                           rsp_end_of_stream;

   modport source (output valid, rsp_out_byte, rsp_out_bit_count, rsp_end_of_stream,
                   input ready);
   modport sink   (input valid, rsp_out_byte, rsp_out_bit_count, rsp_end_of_stream,
                   output ready);
endinterface

// ===== src/hbe_ram.sv =====
module hbe_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/hbe_pack.sv =====
module hbe_pack (
   input  logic                  clock,
   input  logic                  reset,
   input  hbe_pkg::pack_in_type  pin,
   output hbe_pkg::pack_out_type pout
);
   import hbe_pkg::*;

   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0] pend_count_ff, pend_count_in;

   logic [ACC_W-1:0]  acc;
   logic [ACNT_W-1:0] cnt;
   logic [ACNT_W-1:0] sh_hi;
   logic [ACNT_W-1:0] sh_lo;
   logic [ACC_W-1:0]  acc_hi;
   logic [ACC_W-1:0]  acc_lo;
   logic [ACNT_W-1:0] rem;
   logic [PCNT_W-1:0] rem_cnt;
   logic [BYTE_BITS-1:0] rem_mask;

   always_comb begin
      acc    = (ACC_W'(pend_bits_ff) << pin.entry.len) | ACC_W'(pin.entry.code);
      cnt    = ACNT_W'(pend_count_ff) + ACNT_W'(pin.entry.len);
      sh_hi  = cnt - ACNT_W'(BYTE_BITS);
      sh_lo  = cnt - ACNT_W'(2 * BYTE_BITS);
      acc_hi = acc >> sh_hi;
      acc_lo = acc >> sh_lo;

      pout.byte0  = acc_hi[BYTE_BITS-1:0];
      pout.byte1  = acc_lo[BYTE_BITS-1:0];
      pout.count0 = FULL_BYTE_COUNT;
      pout.eos0   = 1'b0;

      if (cnt >= ACNT_W'(2 * BYTE_BITS)) begin
         pout.n = NRES_W'(2);
         rem    = sh_lo;
      end else if (cnt >= ACNT_W'(BYTE_BITS)) begin
         pout.n = NRES_W'(1);
         rem    = sh_hi;
      end else begin
         pout.n = NRES_W'(0);
         rem    = cnt;
      end
      rem_cnt  = rem[PCNT_W-1:0];
      rem_mask = (BYTE_BITS'(1) << rem_cnt) - BYTE_BITS'(1);

      pend_bits_in  = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
      pend_count_in = rem_cnt;

      if (pin.flush) begin
         // emit the leftover bits right-aligned and empty the accumulator
         pout.n        = (pend_count_ff != '0) ? NRES_W'(1) : NRES_W'(0);
         pout.byte0    = BYTE_BITS'(pend_bits_ff);
         pout.count0   = OCNT_W'(pend_count_ff);
         pout.eos0     = 1'b1;
         pend_bits_in  = '0;
         pend_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
      end else if (pin.valid) begin
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
      end
   end

endmodule

// ===== src/hbe_outbuf.sv =====
module hbe_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hbe_pkg::pack_out_type res,
   output logic                  free,
   hbe_rsp_if.source             rsp
);
   import hbe_pkg::*;

   logic [NRES_W-1:0]    num_ff, num_in;
   logic [BYTE_BITS-1:0] byte0_ff, byte0_in;
   logic [OCNT_W-1:0]    count0_ff, count0_in;
   logic                 eos0_ff, eos0_in;
   logic [BYTE_BITS-1:0] byte1_ff, byte1_in;
   logic                 pop;

   assign pop  = rsp.valid && rsp.ready;
   assign free = (num_ff == '0) || ((num_ff == NRES_W'(1)) && pop);

   always_comb begin
      num_in    = num_ff;
      byte0_in  = byte0_ff;
      count0_in = count0_ff;
      eos0_in   = eos0_ff;
      byte1_in  = byte1_ff;
      if (load) begin
         num_in    = res.n;
         byte0_in  = res.byte0;
         count0_in = res.count0;
         eos0_in   = res.eos0;
         byte1_in  = res.byte1;
      end else if (pop) begin
         // advance the second byte to the head
         num_in    = num_ff - NRES_W'(1);
         byte0_in  = byte1_ff;
         count0_in = FULL_BYTE_COUNT;
         eos0_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
      end else begin
         num_ff <= num_in;
      end
      byte0_ff  <= byte0_in;
      count0_ff <= count0_in;
      eos0_ff   <= eos0_in;
      byte1_ff  <= byte1_in;
   end

   assign rsp.valid             = (num_ff != '0);
   assign rsp.rsp_out_byte      = byte0_ff;
   assign rsp.rsp_out_bit_count = count0_ff;
   assign rsp.rsp_end_of_stream = eos0_ff;

endmodule

// ===== src/huffman_bitstream_encoder.sv =====
// Streaming Huffman bit packer for byte symbols. Request beats either load a
// code table entry (req_type write: code bits right-aligned, length 0..16;
// longer lengths or symbols beyond the alphabet are dropped), encode a symbol
// (its code is appended MSB first; each completed group of eight bits leaves
// as one response beat with the earliest bit in bit 7), or flush (the 1..7
// leftover bits leave right-aligned in one beat flagged end_of_stream; an
// empty flush produces nothing). A symbol must be written before it is
// encoded. Timing: the table is a synchronous RAM, so a beat waits in the
// lookup register while the table read lands and then passes through the
// output register to the response port. A request beat can enter every cycle
// while the output register can take its bytes; the response port moves one
// byte per cycle while it is ready, and an encode that completes two bytes
// holds the output register until both have left. Back-pressure on the
// response port reaches the request ready in the same cycle.
`include "assert_macros.svh"

module huffman_bitstream_encoder #(
   parameter int MAX_CODE_LEN = 16,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic      clock,
   input  logic      reset,
   hbe_req_if.sink   req,
   hbe_rsp_if.source rsp
);
   import hbe_pkg::*;

   localparam int ADDR_W = $clog2(SYMBOL_COUNT);
   localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
   localparam int               LEN_MAX   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_MAX);

   req_kind_type kind;
   logic         req_fire;
   logic         sym_ok;
   logic         len_ok;
   logic         wr_en;
   logic         rd_en;
   logic         s1_load;
   logic         s1_adv;
   logic         ob_free;

   logic [CODE_W:0]   len_mask;
   entry_type         wr_entry;
   entry_type         rd_entry;

   // lookup stage: holds one encode or flush beat while the table read lands
   logic s1_valid_ff, s1_valid_in;
   logic s1_flush_ff, s1_flush_in;

   pack_in_type  pk_in;
   pack_out_type pk_out;

   assign kind     = req_kind_type'(req.req_type);
   assign req_fire = req.valid && req.ready;
   assign sym_ok   = ({1'b0, req.req_symbol} < SYM_LIMIT);
   assign len_ok   = (req.req_code_length <= LEN_LIMIT);

   // drop code bits above the stated length before they reach the table
   assign len_mask      = ((CODE_W + 1)'(1) << req.req_code_length) - (CODE_W + 1)'(1);
   assign wr_entry.len  = req.req_code_length;
   assign wr_entry.code = req.req_code_word & len_mask[CODE_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      s1_load = 1'b0;
      unique case (kind)
         REQ_WRITE: begin
            wr_en = req_fire && sym_ok && len_ok;
         end
         REQ_ENCODE: begin
            rd_en   = req_fire && sym_ok;
            s1_load = req_fire && sym_ok;
         end
         REQ_FLUSH: begin
            s1_load = req_fire;
         end
         default: begin
            // unknown request: accept and drop
         end
      endcase
   end

   hbe_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SYMBOL_COUNT)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req.req_symbol[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (req.req_symbol[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   // advance the lookup beat once the output register can take its bytes
   assign s1_adv    = s1_valid_ff && ob_free;
   assign req.ready = !s1_valid_ff || ob_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_flush_in = s1_flush_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
         s1_flush_in = (kind == REQ_FLUSH);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_flush_ff <= s1_flush_in;
   end

   assign pk_in.valid = s1_adv;
   assign pk_in.flush = s1_flush_ff;
   assign pk_in.entry = rd_entry;

   hbe_pack u_pack (
      .clock (clock),
      .reset (reset),
      .pin   (pk_in),
      .pout  (pk_out)
   );

   hbe_outbuf u_outbuf (
      .clock (clock),
      .reset (reset),
      .load  (s1_adv),
      .res   (pk_out),
      .free  (ob_free),
      .rsp   (rsp)
   );

   `ASSERT_NEXT(a_lookup_load, s1_load, s1_valid_ff, "accepted beat did not reach lookup stage")
   `ASSERT_CLK(a_ready_stall, !req.ready |-> s1_valid_ff, "ready low with empty lookup stage")
   `ASSERT_CLK(a_eos_count, rsp.valid && rsp.rsp_end_of_stream |-> rsp.rsp_out_bit_count != '0 && rsp.rsp_out_bit_count != FULL_BYTE_COUNT, "final byte has bad bit count")
   `ASSERT_CLK(a_full_count, rsp.valid && !rsp.rsp_end_of_stream |-> rsp.rsp_out_bit_count == FULL_BYTE_COUNT, "packed byte is not full")

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   import hbe_pkg::*;

   // Match the block's default parameters.
   localparam int MAX_CODE_LEN = 16;
   localparam int SYMBOL_COUNT = 256;

   // Request code with no meaning; the block must drop such a beat.
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam int IDLE_PERCENT = 22;
   localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
   localparam int SETTLE_CYCLES = 20;   // tail after the last expected byte
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic [OCNT_W-1:0]    bit_count;
      logic                 eos;
   } packed_byte_type;

   logic clock;
   logic reset;

   hbe_req_if req_ch ();
   hbe_rsp_if rsp_ch ();

   huffman_bitstream_encoder #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Mirror of the encoder: code table plus the bits not yet packed into a byte.
   logic [LEN_W-1:0]  code_len_tbl  [SYMBOL_COUNT];
   logic [CODE_W-1:0] code_bits_tbl [SYMBOL_COUNT];
   bit                entry_written [SYMBOL_COUNT];
   logic [7:0]        written_syms  [$];
   logic [PEND_W-1:0] held_bits;
   logic [PCNT_W-1:0] held_count;

   packed_byte_type expected_bytes [$];

   int  mismatches;
   int  idle_cycles;
   bit  sender_gaps;
   bit  sink_stalls;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Count a failure; show only the first few.
   function automatic void flag_error(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch: %s", msg);
   endfunction

   // Advance the mirror by one accepted request beat and queue the bytes it yields.
   task automatic model_bit_packer(input logic [1:0] kind, input logic [7:0] sym,
                                   input logic [CODE_W-1:0] word,
                                   input logic [LEN_W-1:0] len);
      logic [ACC_W-1:0] acc;
      packed_byte_type  beat;
      int unsigned      cnt;
      int unsigned      clen;
      int unsigned      nout;
      nout = 0;
      case (kind)
         REQ_WRITE: begin
            // Drop overlong codes; keep only the low len bits of the word.
            if (sym < SYMBOL_COUNT && len <= MAX_CODE_LEN && len <= CODE_W) begin
               code_len_tbl[sym]  = len;
               code_bits_tbl[sym] = word & CODE_W'((32'd1 << len) - 1);
               if (!entry_written[sym]) begin
                  entry_written[sym] = 1'b1;
                  written_syms.insert(written_syms.size(), sym);
               end
            end
         end
         REQ_ENCODE: begin
            if (sym < SYMBOL_COUNT) begin
               clen = code_len_tbl[sym];
               acc  = (ACC_W'(held_bits) << clen) | ACC_W'(code_bits_tbl[sym]);
               cnt  = held_count + clen;
               while (cnt >= BYTE_BITS && nout < 2) begin
                  beat.data_byte = BYTE_BITS'(acc >> (cnt - BYTE_BITS));
                  beat.bit_count = FULL_BYTE_COUNT;
                  beat.eos       = 1'b0;
                  expected_bytes.insert(expected_bytes.size(), beat);
                  cnt -= BYTE_BITS;
                  nout++;
               end
               held_count = PCNT_W'(cnt);
               held_bits  = PEND_W'(acc) & PEND_W'((32'd1 << cnt) - 1);
            end
         end
         REQ_FLUSH: begin
            // Empty flush yields nothing; otherwise one right-aligned final byte.
            if (held_count != 0) begin
               beat.data_byte = BYTE_BITS'(held_bits);
               beat.bit_count = OCNT_W'(held_count);
               beat.eos       = 1'b1;
               expected_bytes.insert(expected_bytes.size(), beat);
            end
            held_bits  = '0;
            held_count = '0;
         end
         default: ;
      endcase
   endtask

   // Send one request beat. Entered and left at a falling edge; valid stays high
   // between back-to-back beats and drops only during a gap.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] sym,
                            input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
      while (sender_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid           = 1'b1;
      req_ch.req_type        = kind;
      req_ch.req_symbol      = sym;
      req_ch.req_code_word   = word;
      req_ch.req_code_length = len;
      forever begin
         @(posedge clock);
         if (req_ch.ready)
            break;
      end
      model_bit_packer(kind, sym, word, len);
      @(negedge clock);
   endtask

   // Hold the request side idle until every queued byte has come back.
   task automatic wait_for_drain();
      req_ch.valid = 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly well-formed traffic: encodes of loaded symbols, some table reloads,
   // occasional flushes, and a little noise (overlong codes, reserved requests).
   task automatic send_random_beat();
      int unsigned pick;
      logic [LEN_W-1:0] len;
      pick = $urandom_range(99);
      if (pick < 15) begin
         if ($urandom_range(99) < 85)
            len = LEN_W'($urandom_range(MAX_CODE_LEN));
         else
            len = LEN_W'($urandom_range(31, MAX_CODE_LEN + 1));
         send_beat(REQ_WRITE, 8'($urandom), CODE_W'($urandom), len);
      end else if (pick < 90) begin
         send_beat(REQ_ENCODE, written_syms[$urandom_range(written_syms.size() - 1)],
                   CODE_W'($urandom), LEN_W'($urandom));
      end else if (pick < 96) begin
         send_beat(REQ_FLUSH, 8'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end else begin
         send_beat(REQ_RESERVED, 8'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end
   endtask

   // Edge cases of the table and of the packer, one beat at a time.
   task automatic test_table_and_edges();
      send_beat(REQ_FLUSH,    8'd0,   16'h0000, 5'd0);   // flush with nothing held
      send_beat(REQ_RESERVED, 8'd7,   16'hFFFF, 5'd31);  // reserved request
      send_beat(REQ_WRITE,    8'd0,   16'hFFFF, 5'd0);   // zero-length code
      send_beat(REQ_WRITE,    8'd255, 16'hFFFF, 5'd16);  // longest code, all ones
      send_beat(REQ_WRITE,    8'd1,   16'h0001, 5'd1);
      send_beat(REQ_WRITE,    8'd2,   16'hFFFA, 5'd3);   // stray bits above length
      send_beat(REQ_WRITE,    8'd3,   16'h0000, 5'd16);  // longest code, all zeros
      send_beat(REQ_WRITE,    8'd4,   16'h00A5, 5'd8);
      send_beat(REQ_WRITE,    8'd4,   16'h1234, 5'd17);  // overlong: keep old entry
      send_beat(REQ_WRITE,    8'd5,   16'hFFFF, 5'd31);  // overlong on empty entry
      send_beat(REQ_ENCODE,   8'd0,   16'hFFFF, 5'd31);  // appends nothing
      send_beat(REQ_ENCODE,   8'd1,   16'h0000, 5'd0);
      send_beat(REQ_FLUSH,    8'd255, 16'hFFFF, 5'd31);  // one-bit final byte
      send_beat(REQ_ENCODE,   8'd255, 16'h5555, 5'd10);  // two bytes at once
      send_beat(REQ_ENCODE,   8'd2,   16'h0000, 5'd0);
      send_beat(REQ_ENCODE,   8'd3,   16'h0000, 5'd0);   // two bytes, three left
      send_beat(REQ_ENCODE,   8'd4,   16'h0000, 5'd0);
      send_beat(REQ_ENCODE,   8'd255, 16'h0000, 5'd0);
      send_beat(REQ_RESERVED, 8'd1,   16'h0000, 5'd0);   // must not disturb held bits
      send_beat(REQ_ENCODE,   8'd1,   16'h0000, 5'd0);
      send_beat(REQ_ENCODE,   8'd2,   16'h0000, 5'd0);
      send_beat(REQ_FLUSH,    8'd0,   16'h0000, 5'd0);   // seven-bit final byte
      send_beat(REQ_FLUSH,    8'd0,   16'h0000, 5'd0);
      send_beat(REQ_ENCODE,   8'd0,   16'h0000, 5'd0);
   endtask

   // Stop the sender mid-stream until the pipeline is empty, then resume.
   task automatic test_drain_pause();
      repeat (30) send_random_beat();
      wait_for_drain();
      repeat (30) send_random_beat();
   endtask

   // Back-to-back traffic on both sides with no idling at all.
   task automatic test_unbroken_stream();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      repeat (300) send_random_beat();
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
   endtask

   // Long random run with idling on both sides and a drain every so often.
   task automatic test_random_stream();
      for (int i = 0; i < 1650; i++) begin
         send_random_beat();
         if (i % 500 == 499)
            wait_for_drain();
      end
   endtask

   // Result side: stall at random, check each accepted beat against the queue.
   always @(negedge clock) begin
      rsp_ch.ready = !(sink_stalls && $urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            flag_error($sformatf("unexpected byte %h count %0d eos %b",
                                 rsp_ch.rsp_out_byte, rsp_ch.rsp_out_bit_count,
                                 rsp_ch.rsp_end_of_stream));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_ch.rsp_out_byte !== want.data_byte)
               flag_error($sformatf("out_byte expected %h got %h",
                                    want.data_byte, rsp_ch.rsp_out_byte));
            if (rsp_ch.rsp_out_bit_count !== want.bit_count)
               flag_error($sformatf("out_bit_count expected %0d got %0d",
                                    want.bit_count, rsp_ch.rsp_out_bit_count));
            if (rsp_ch.rsp_end_of_stream !== want.eos)
               flag_error($sformatf("end_of_stream expected %b got %b",
                                    want.eos, rsp_ch.rsp_end_of_stream));
         end
      end
   end

   // Watchdog: end the run if no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.req_type        = REQ_WRITE;
      req_ch.req_symbol      = '0;
      req_ch.req_code_word   = '0;
      req_ch.req_code_length = '0;
      rsp_ch.ready           = 1'b0;
      mismatches             = 0;
      idle_cycles            = 0;
      held_bits              = '0;
      held_count             = '0;
      sender_gaps            = 1'b1;
      sink_stalls            = 1'b1;
      for (int s = 0; s < SYMBOL_COUNT; s++) begin
         code_len_tbl[s]  = '0;
         code_bits_tbl[s] = '0;
         entry_written[s] = 1'b0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_table_and_edges();
      test_drain_pause();
      test_unbroken_stream();
      test_random_stream();

      // Let the last bytes come out, then allow a short tail for strays.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0)
         flag_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
